@@ sv/ihpq_pkg.sv @@
// Package with the types, constants and codes of the indexed max-heap queue.
`default_nettype none
package ihpq_pkg;

   localparam int CAPACITY = 64;
   localparam int POS_W    = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ID_W     = 6;
   localparam int PRIO_W   = 32;
   localparam int FUNC_W   = 3;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_RAISE  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOWER  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd4;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOK   = 6'b000010,
      ST_UP_RD  = 6'b000100,
      ST_UP_CMP = 6'b001000,
      ST_DN_RD  = 6'b010000,
      ST_DN_CMP = 6'b100000
   } state_type;

   // One heap slot: the id stored there and a copy of its priority.
   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
   } heap_word_type;

   // One entry record, indexed by id.
   typedef struct packed {
      logic [POS_W-1:0]         pos;
      logic signed [PRIO_W-1:0] prio;
   } entry_word_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      heap_word_type    data;
   } heap_wr_type;

   typedef struct packed {
      logic           en;
      logic [ID_W-1:0] addr;
      entry_word_type data;
   } entry_wr_type;

endpackage
`default_nettype wire

@@ sv/ihpq_heap_mem.sv @@
// Heap slot memory: one write port and two registered read ports.
`default_nettype none
module ihpq_heap_mem (
   input  wire logic                        clock,
   input  wire ihpq_pkg::heap_wr_type       wr,
   input  wire logic [ihpq_pkg::POS_W-1:0]  rd_addr_a,
   input  wire logic [ihpq_pkg::POS_W-1:0]  rd_addr_b,
   output ihpq_pkg::heap_word_type          q_a,
   output ihpq_pkg::heap_word_type          q_b
);

   ihpq_pkg::heap_word_type mem [ihpq_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      q_a <= mem[rd_addr_a];
      q_b <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

@@ sv/ihpq_entry_mem.sv @@
// Entry memory indexed by id: heap position and priority of each id.
`default_nettype none
module ihpq_entry_mem (
   input  wire logic                       clock,
   input  wire ihpq_pkg::entry_wr_type     wr,
   input  wire logic [ihpq_pkg::ID_W-1:0]  rd_addr,
   output ihpq_pkg::entry_word_type        q
);

   ihpq_pkg::entry_word_type mem [ihpq_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      q <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ sv/indexed_max_heap_priority_queue.sv @@
// Top level of the indexed binary max-heap priority queue.
//
//   channel   ports                                          handshake
//   request   req_func, req_entry_id, req_priority_in        start && !busy
//   response  rsp_ok, rsp_out_id, rsp_out_priority,          rsp_valid, one cycle
//             rsp_entry_count
//
// A query, a failed operation or a remove that empties the heap is answered
// from the look-up state with a registered response strobe. A sift adds a
// slot read and a compare and write-back for each level it moves the item,
// and ends with a write-back at the level where it stops. Reset is
// synchronous and leaves the heap empty; the response strobe rises in the
// cycle busy falls and cannot be stalled.
`default_nettype none
module indexed_max_heap_priority_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ihpq_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [ihpq_pkg::ID_W-1:0]     req_entry_id,
   input  wire logic signed [ihpq_pkg::PRIO_W-1:0] req_priority_in,
   output logic                               rsp_valid,
   output logic                               rsp_ok,
   output logic [ihpq_pkg::ID_W-1:0]          rsp_out_id,
   output logic signed [ihpq_pkg::PRIO_W-1:0] rsp_out_priority,
   output logic [ihpq_pkg::COUNT_W-1:0]       rsp_entry_count
);

   ihpq_pkg::state_type               state_ff, state_in;
   logic [ihpq_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic [ihpq_pkg::ID_W-1:0]         id_ff, id_in;
   logic signed [ihpq_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic [ihpq_pkg::POS_W-1:0]        pos_ff, pos_in;
   ihpq_pkg::heap_word_type           carry_ff, carry_in;
   logic [ihpq_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [ihpq_pkg::CAPACITY-1:0]     present_ff, present_in;
   logic                              valid_ff, valid_in;
   logic                              res_ok_ff, res_ok_in;
   logic [ihpq_pkg::ID_W-1:0]         res_id_ff, res_id_in;
   logic signed [ihpq_pkg::PRIO_W-1:0] res_prio_ff, res_prio_in;

   ihpq_pkg::heap_wr_type             heap_wr;
   ihpq_pkg::entry_wr_type            entry_wr;
   logic [ihpq_pkg::POS_W-1:0]        heap_rd_a, heap_rd_b;
   ihpq_pkg::heap_word_type           heap_q_a, heap_q_b;
   ihpq_pkg::entry_word_type          entry_q;

   logic [ihpq_pkg::COUNT_W-1:0]      left_w;
   logic [ihpq_pkg::COUNT_W:0]        right_w;
   logic [ihpq_pkg::POS_W-1:0]        parent_w;
   logic                              take_right;
   ihpq_pkg::heap_word_type           child_w;
   logic [ihpq_pkg::POS_W-1:0]        child_pos_w;

   ihpq_heap_mem u_heap_mem (
      .clock     (clock),
      .wr        (heap_wr),
      .rd_addr_a (heap_rd_a),
      .rd_addr_b (heap_rd_b),
      .q_a       (heap_q_a),
      .q_b       (heap_q_b)
   );

   ihpq_entry_mem u_entry_mem (
      .clock   (clock),
      .wr      (entry_wr),
      .rd_addr (req_entry_id),
      .q       (entry_q)
   );

   assign left_w   = {pos_ff, 1'b1};
   assign right_w  = {1'b0, left_w} + {{ihpq_pkg::COUNT_W{1'b0}}, 1'b1};
   assign parent_w = (pos_ff - {{(ihpq_pkg::POS_W-1){1'b0}}, 1'b1}) >> 1;
   assign take_right = (right_w < {1'b0, count_ff}) && (heap_q_b.prio > heap_q_a.prio);
   assign child_w     = take_right ? heap_q_b : heap_q_a;
   assign child_pos_w = take_right ? right_w[ihpq_pkg::POS_W-1:0]
                                   : left_w[ihpq_pkg::POS_W-1:0];

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      id_in       = id_ff;
      prio_in     = prio_ff;
      pos_in      = pos_ff;
      carry_in    = carry_ff;
      count_in    = count_ff;
      present_in  = present_ff;
      valid_in    = 1'b0;
      res_ok_in   = res_ok_ff;
      res_id_in   = res_id_ff;
      res_prio_in = res_prio_ff;
      heap_wr     = '0;
      entry_wr    = '0;
      heap_rd_a   = '0;
      heap_rd_b   = count_ff[ihpq_pkg::POS_W-1:0] - {{(ihpq_pkg::POS_W-1){1'b0}}, 1'b1};

      case (state_ff)
         ihpq_pkg::ST_IDLE: begin
            if (start) begin
               func_in  = req_func;
               id_in    = req_entry_id;
               prio_in  = req_priority_in;
               state_in = ihpq_pkg::ST_LOOK;
            end
         end
         ihpq_pkg::ST_LOOK: begin
            res_ok_in   = 1'b0;
            res_id_in   = id_ff;
            res_prio_in = '0;
            carry_in    = '{id: id_ff, prio: prio_ff};
            state_in    = ihpq_pkg::ST_IDLE;
            valid_in    = 1'b1;
            case (func_ff)
               ihpq_pkg::FUNC_INSERT: begin
                  if (!present_ff[id_ff] && count_ff < ihpq_pkg::COUNT_W'(ihpq_pkg::CAPACITY)) begin
                     present_in[id_ff] = 1'b1;
                     count_in  = count_ff + 1'b1;
                     pos_in    = count_ff[ihpq_pkg::POS_W-1:0];
                     res_ok_in = 1'b1;
                     state_in  = ihpq_pkg::ST_UP_RD;
                     valid_in  = 1'b0;
                  end
               end
               ihpq_pkg::FUNC_RAISE: begin
                  if (present_ff[id_ff] && entry_q.prio < prio_ff) begin
                     pos_in    = entry_q.pos;
                     res_ok_in = 1'b1;
                     state_in  = ihpq_pkg::ST_UP_RD;
                     valid_in  = 1'b0;
                  end
               end
               ihpq_pkg::FUNC_LOWER: begin
                  if (present_ff[id_ff] && entry_q.prio > prio_ff) begin
                     pos_in    = entry_q.pos;
                     res_ok_in = 1'b1;
                     state_in  = ihpq_pkg::ST_DN_RD;
                     valid_in  = 1'b0;
                  end
               end
               ihpq_pkg::FUNC_REMOVE: begin
                  if (count_ff == '0) begin
                     res_id_in = '0;
                  end else begin
                     res_ok_in   = 1'b1;
                     res_id_in   = heap_q_a.id;
                     res_prio_in = heap_q_a.prio;
                     present_in[heap_q_a.id] = 1'b0;
                     count_in    = count_ff - 1'b1;
                     // The last slot moves to the root and sinks from there.
                     if (count_ff != ihpq_pkg::COUNT_W'(1)) begin
                        carry_in = heap_q_b;
                        pos_in   = '0;
                        state_in = ihpq_pkg::ST_DN_RD;
                        valid_in = 1'b0;
                     end
                  end
               end
               ihpq_pkg::FUNC_QUERY: begin
                  if (present_ff[id_ff]) begin
                     res_ok_in   = 1'b1;
                     res_prio_in = entry_q.prio;
                  end
               end
               default: begin
               end
            endcase
         end
         ihpq_pkg::ST_UP_RD: begin
            heap_rd_a = parent_w;
            if (pos_ff == '0) begin
               heap_wr  = '{en: 1'b1, addr: pos_ff, data: carry_ff};
               entry_wr = '{en: 1'b1, addr: carry_ff.id,
                            data: '{pos: pos_ff, prio: carry_ff.prio}};
               state_in = ihpq_pkg::ST_IDLE;
               valid_in = 1'b1;
            end else begin
               state_in = ihpq_pkg::ST_UP_CMP;
            end
         end
         ihpq_pkg::ST_UP_CMP: begin
            if (heap_q_a.prio < carry_ff.prio) begin
               heap_wr  = '{en: 1'b1, addr: pos_ff, data: heap_q_a};
               entry_wr = '{en: 1'b1, addr: heap_q_a.id,
                            data: '{pos: pos_ff, prio: heap_q_a.prio}};
               pos_in   = parent_w;
               state_in = ihpq_pkg::ST_UP_RD;
            end else begin
               heap_wr  = '{en: 1'b1, addr: pos_ff, data: carry_ff};
               entry_wr = '{en: 1'b1, addr: carry_ff.id,
                            data: '{pos: pos_ff, prio: carry_ff.prio}};
               state_in = ihpq_pkg::ST_IDLE;
               valid_in = 1'b1;
            end
         end
         ihpq_pkg::ST_DN_RD: begin
            heap_rd_a = left_w[ihpq_pkg::POS_W-1:0];
            heap_rd_b = right_w[ihpq_pkg::POS_W-1:0];
            if (left_w >= count_ff) begin
               heap_wr  = '{en: 1'b1, addr: pos_ff, data: carry_ff};
               entry_wr = '{en: 1'b1, addr: carry_ff.id,
                            data: '{pos: pos_ff, prio: carry_ff.prio}};
               state_in = ihpq_pkg::ST_IDLE;
               valid_in = 1'b1;
            end else begin
               state_in = ihpq_pkg::ST_DN_CMP;
            end
         end
         ihpq_pkg::ST_DN_CMP: begin
            if (child_w.prio > carry_ff.prio) begin
               heap_wr  = '{en: 1'b1, addr: pos_ff, data: child_w};
               entry_wr = '{en: 1'b1, addr: child_w.id,
                            data: '{pos: pos_ff, prio: child_w.prio}};
               pos_in   = child_pos_w;
               state_in = ihpq_pkg::ST_DN_RD;
            end else begin
               heap_wr  = '{en: 1'b1, addr: pos_ff, data: carry_ff};
               entry_wr = '{en: 1'b1, addr: carry_ff.id,
                            data: '{pos: pos_ff, prio: carry_ff.prio}};
               state_in = ihpq_pkg::ST_IDLE;
               valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ihpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ihpq_pkg::ST_IDLE;
         count_ff   <= '0;
         present_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         present_ff <= present_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      id_ff       <= id_in;
      prio_ff     <= prio_in;
      pos_ff      <= pos_in;
      carry_ff    <= carry_in;
      res_ok_ff   <= res_ok_in;
      res_id_ff   <= res_id_in;
      res_prio_ff <= res_prio_in;
   end

   assign busy             = (state_ff != ihpq_pkg::ST_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_ok           = res_ok_ff;
   assign rsp_out_id       = res_id_ff;
   assign rsp_out_priority = res_prio_ff;
   assign rsp_entry_count  = count_ff;

endmodule
`default_nettype wire

@@ sv/ihpq_checker.sv @@
// Port-level checker for the indexed max-heap queue, bound to the top level.
`default_nettype none
module ihpq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic [ihpq_pkg::COUNT_W-1:0]  rsp_entry_count
);

   // A result appears only once the block has gone idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted item always keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Each item gives one result, never two in a row.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // The count never exceeds the heap capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= ihpq_pkg::COUNT_W'(ihpq_pkg::CAPACITY))
      else $error("entry count above capacity");

   // A result strobe is always preceded by a busy cycle.
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> $past(busy))
      else $error("result without work");

endmodule

bind indexed_max_heap_priority_queue ihpq_checker u_ihpq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_entry_count (rsp_entry_count)
);
`default_nettype wire
